// File: sv/fan_mode_keypress_setter_macros.svh
// Assertion macros for the fan mode keypress setter.
// Included by the top level; no other dependencies.
`ifndef FAN_MODE_KEYPRESS_SETTER_MACROS_SVH
`define FAN_MODE_KEYPRESS_SETTER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define FMKS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define FMKS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/fmks_pkg.sv
// Shared types and constants for the fan mode keypress setter.
// No dependencies.
`default_nettype none

package fmks_pkg;

    // Configuration register indexes
    localparam logic REG_PRESS_TIME  = 1'b0;
    localparam logic REG_RETRY_LIMIT = 1'b1;

    localparam int unsigned PADDR_W = 3;
    localparam int unsigned PDATA_W = 32;

    // Register reset values
    localparam logic [15:0] PRESS_TIME_RST  = 16'd100;
    localparam logic [3:0]  RETRY_LIMIT_RST = 4'd10;

    // Indicator line patterns for each valid mode
    localparam logic [2:0] LEVELS_MODE0 = 3'b111;
    localparam logic [2:0] LEVELS_MODE1 = 3'b110;
    localparam logic [2:0] LEVELS_MODE2 = 3'b101;
    localparam logic [2:0] LEVELS_MODE3 = 3'b011;

    localparam logic [2:0] MODE_0       = 3'd0;
    localparam logic [2:0] MODE_1       = 3'd1;
    localparam logic [2:0] MODE_2       = 3'd2;
    localparam logic [2:0] MODE_3       = 3'd3;
    localparam logic [2:0] MODE_INVALID = 3'd4;

    // Operation codes
    localparam logic OP_SCAN = 1'b0;
    localparam logic OP_SET  = 1'b1;

    typedef enum logic [1:0] {
        PHASE_IDLE    = 2'd0,
        PHASE_PRESS   = 2'd1,
        PHASE_RELEASE = 2'd2
    } key_phase_t;

    typedef struct packed {
        logic        operation;
        logic [2:0]  level_bits;
        logic [1:0]  req_mode;
        logic [31:0] time_ms;
    } fmks_item_t;

    typedef struct packed {
        logic [2:0] mode_seen;
        logic       in_target;
        logic       failed;
        logic       key_level;
        logic [3:0] retries_done;
    } fmks_result_t;

    typedef struct packed {
        logic [15:0] press_time;
        logic [3:0]  retry_limit;
    } fmks_cfg_t;

    typedef struct packed {
        logic [1:0]  goal_mode;
        logic [2:0]  last_mode;
        logic        ok_flag;
        logic        fail_flag;
        logic [3:0]  retry_count;
        key_phase_t  key_phase;
        logic [31:0] phase_start;
        logic        key_out;
    } fmks_state_t;

endpackage

`default_nettype wire

// File: sv/fmks_regs.sv
// APB-style configuration registers: press time and retry limit.
// Depends on fmks_pkg.
`default_nettype none

module fmks_regs
    import fmks_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output fmks_cfg_t               cfg
);

    fmks_cfg_t cfg_reg;
    fmks_cfg_t cfg_next;
    logic      wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Register write decode; word index is paddr[2]
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (paddr[2])
                REG_PRESS_TIME:  cfg_next.press_time  = pwdata[15:0];
                REG_RETRY_LIMIT: cfg_next.retry_limit = pwdata[3:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.press_time  <= PRESS_TIME_RST;
            cfg_reg.retry_limit <= RETRY_LIMIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read mux
    always_comb
    begin
        case (paddr[2])
            REG_PRESS_TIME:  prdata = {{(PDATA_W-16){1'b0}}, cfg_reg.press_time};
            REG_RETRY_LIMIT: prdata = {{(PDATA_W-4){1'b0}}, cfg_reg.retry_limit};
            default:         prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: sv/fmks_update.sv
// Next-state logic for one item: mode decode, target compare, retry
// counting and the key press sequencer. Depends on fmks_pkg.
`default_nettype none

module fmks_update
    import fmks_pkg::*;
(
    input  wire fmks_state_t state,
    input  wire fmks_item_t  item,
    input  wire fmks_cfg_t   cfg,
    output fmks_state_t      state_next
);

    logic [2:0]  mode;
    logic [31:0] elapsed;
    logic        phase_done;

    // Indicator decode
    always_comb
    begin
        case (item.level_bits)
            LEVELS_MODE0: mode = MODE_0;
            LEVELS_MODE1: mode = MODE_1;
            LEVELS_MODE2: mode = MODE_2;
            LEVELS_MODE3: mode = MODE_3;
            default:      mode = MODE_INVALID;
        endcase
    end

    // Phase timer, wraps modulo 2^32
    assign elapsed    = item.time_ms - state.phase_start;
    assign phase_done = elapsed >= {16'd0, cfg.press_time};

    always_comb
    begin
        state_next = state;
        if (item.operation == OP_SET)
        begin
            state_next.goal_mode   = item.req_mode;
            state_next.ok_flag     = 1'b0;
            state_next.fail_flag   = 1'b0;
            state_next.retry_count = 4'd0;
            state_next.phase_start = item.time_ms;
            state_next.key_phase   = PHASE_IDLE;
        end
        else
        begin
            state_next.last_mode = mode;
            if (!state.fail_flag)
            begin
                if (mode == {1'b0, state.goal_mode})
                begin
                    state_next.ok_flag     = 1'b1;
                    state_next.retry_count = 4'd0;
                end
                else
                begin
                    state_next.ok_flag = 1'b0;
                    if (state.retry_count < cfg.retry_limit)
                    begin
                        state_next.retry_count = state.retry_count + 4'd1;
                        // One sequencer step
                        case (state.key_phase)
                            PHASE_PRESS:
                            begin
                                if (phase_done)
                                begin
                                    state_next.key_out     = 1'b1;
                                    state_next.phase_start = item.time_ms;
                                    state_next.key_phase   = PHASE_RELEASE;
                                end
                            end
                            PHASE_RELEASE:
                            begin
                                if (phase_done)
                                begin
                                    state_next.key_phase = PHASE_IDLE;
                                end
                            end
                            default:
                            begin
                                state_next.key_out     = 1'b0;
                                state_next.phase_start = item.time_ms;
                                state_next.key_phase   = PHASE_PRESS;
                            end
                        endcase
                    end
                    else
                    begin
                        state_next.fail_flag   = 1'b1;
                        state_next.retry_count = 4'd0;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: sv/fan_mode_keypress_setter.sv
// Top level of the fan mode keypress setter: input register, state,
// result register. Depends on fmks_pkg, fmks_regs, fmks_update.
//
//   channel  | direction | handshake                      | payload
//   item     | in        | item_valid / item_stall        | fmks_item_t
//   result   | out       | result_valid / result_stall    | fmks_result_t
//   config   | in        | APB psel/penable/pwrite/pready | 32-bit data
//
// One item per cycle sustained while no result stalls; an item passes the
// input register, then the result register with the state update.
// Reset resets the state and empties both registers; no clearing pass.
// A stalled result holds the result register and a full input register;
// item_stall rises only when both are full and the result is stalled.
`default_nettype none

module fan_mode_keypress_setter
    import fmks_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_stall,
    input  wire fmks_item_t         item,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output fmks_result_t            result,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    fmks_cfg_t    cfg;
    fmks_item_t   item_reg;
    logic         item_valid_reg;
    fmks_state_t  state_reg;
    fmks_state_t  state_next;
    fmks_result_t result_reg;
    logic         result_valid_reg;
    logic         res_ready;
    logic         item_ready;
    logic         advance;

    fmks_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fmks_update u_update (
        .state      (state_reg),
        .item       (item_reg),
        .cfg        (cfg),
        .state_next (state_next)
    );

    // Pipeline flow control
    assign res_ready  = !result_valid_reg || !result_stall;
    assign advance    = item_valid_reg && res_ready;
    assign item_ready = !item_valid_reg || res_ready;
    assign item_stall = !item_ready;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            item_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
        begin
            item_reg <= item;
        end
    end

    // Block state, updated as an item moves into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.goal_mode   <= 2'd0;
            state_reg.last_mode   <= MODE_0;
            state_reg.ok_flag     <= 1'b0;
            state_reg.fail_flag   <= 1'b0;
            state_reg.retry_count <= 4'd0;
            state_reg.key_phase   <= PHASE_IDLE;
            state_reg.phase_start <= 32'd0;
            state_reg.key_out     <= 1'b1;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            result_valid_reg <= item_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg.mode_seen    <= state_next.last_mode;
            result_reg.in_target    <= state_next.ok_flag;
            result_reg.failed       <= state_next.fail_flag;
            result_reg.key_level    <= state_next.key_out;
            result_reg.retries_done <= state_next.retry_count;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Checks
`include "fan_mode_keypress_setter_macros.svh"

    `FMKS_ASSERT_SAME(a_fail_not_ok, clk, rst_n,
        result_valid && result.failed, !result.in_target,
        "failed and in_target both set")
    `FMKS_ASSERT_SAME(a_fail_zero_retry, clk, rst_n,
        result_valid && result.failed, result.retries_done == 4'd0,
        "retry count not cleared on failure")
    `FMKS_ASSERT_SAME(a_release_key_up, clk, rst_n,
        state_reg.key_phase == PHASE_RELEASE, state_reg.key_out,
        "key still pressed in release phase")
    `FMKS_ASSERT_NEXT(a_transfer_held, clk, rst_n,
        item_valid && !item_stall, item_valid_reg,
        "accepted item lost from input register")

endmodule

`default_nettype wire
